>>> rtl/core/ssis_pkg.sv
// Shared types and codes for the sharded sorted ID set.
// No dependencies.
`default_nettype none
package ssis_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    localparam int unsigned SHARD_IDX_W = 5;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] card_id;
    } req_t;

    typedef struct packed {
        logic                   present;
        logic [1:0]             status;
        logic [SHARD_IDX_W-1:0] shard_index;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/sharded_sorted_id_set.sv
// Sharded sorted ID set: top level, shard tables in one synchronous memory.
// Depends on ssis_pkg.
//
// Each 64-bit ID picks a shard by XOR-folding its halves and reducing modulo
// SHARDS. A lookup takes about log2(ENTRIES_PER_SHARD)+1 memory probes, each
// an address and then a compare of the registered read data. An add or delete
// that changes the table then shifts the entries above the insert point one at
// a time through the single memory port, a read and then a write per entry. One
// item is in work at a time; the result waits in an output register, and no new
// item is taken while rsp_stall holds it there. Fill counts reset to zero at
// once; table contents need no clearing.
`default_nettype none
module sharded_sorted_id_set #(
    parameter int unsigned SHARDS            = 32,
    parameter int unsigned ENTRIES_PER_SHARD = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ssis_pkg::req_t req,
    input  wire logic          req_valid,
    output logic               req_stall,
    output ssis_pkg::rsp_t     rsp,
    output logic               rsp_valid,
    input  wire logic          rsp_stall
);
    localparam int unsigned SH_W  = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int unsigned EN_W  = $clog2(ENTRIES_PER_SHARD);
    localparam int unsigned CNT_W = $clog2(ENTRIES_PER_SHARD + 1);
    localparam int unsigned DEPTH = SHARDS * ENTRIES_PER_SHARD;
    localparam int unsigned AD_W  = $clog2(DEPTH);
    localparam int unsigned FOLD_W = 32;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PROBE  = 7'b0000010,
        S_CMP    = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_SHRD   = 7'b0010000,
        S_SHWR   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     fill_reg [SHARDS];
    logic [1:0]           op_reg;
    logic [63:0]          id_reg;
    logic [SH_W-1:0]      sh_reg;
    logic [CNT_W-1:0]     n_reg, lo_reg, hi_reg, mid_reg, i_reg;
    logic [63:0]          mem [DEPTH];
    logic [63:0]          rd_reg;
    logic                 rsp_valid_reg;
    ssis_pkg::rsp_t       rsp_reg;

    // Fold hash and shard pick
    logic [FOLD_W-1:0]    folded;
    logic [SH_W-1:0]      sh_pick;
    assign folded  = req.card_id[31:0] ^ req.card_id[63:32];
    assign sh_pick = SH_W'(folded % SHARDS);

    // Memory port control
    logic                 mem_we;
    logic [CNT_W-1:0]     mem_off;
    logic [63:0]          mem_wd;
    logic [AD_W-1:0]      mem_addr;
    assign mem_addr = AD_W'(sh_reg) * AD_W'(ENTRIES_PER_SHARD) + AD_W'(mem_off[EN_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        rd_reg <= mem[mem_addr];
    end

    logic hit;
    assign hit = (lo_reg < n_reg) && (rd_reg == id_reg) && (mid_reg == lo_reg);

    logic        hit_reg;
    logic [CNT_W-1:0] pos_reg;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        mem_we  = 1'b0;
        mem_off = mid_reg;
        mem_wd  = rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                mem_off = mid_reg;
                state_next = (lo_reg < hi_reg) ? S_CMP : S_DECIDE;
            end
            S_CMP:
            begin
                state_next = S_PROBE;
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                if (op_reg == ssis_pkg::OP_ADD && !hit && n_reg < CNT_W'(ENTRIES_PER_SHARD))
                begin
                    state_next = S_SHRD;
                end
                if (op_reg == ssis_pkg::OP_DELETE && hit)
                begin
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                // Add: read entry i-1; delete: read entry i+1
                if (op_reg == ssis_pkg::OP_ADD)
                begin
                    mem_off = i_reg - 1'b1;
                end
                else
                begin
                    mem_off = i_reg + 1'b1;
                end
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                mem_off = i_reg;
                if (op_reg == ssis_pkg::OP_ADD)
                begin
                    mem_we = 1'b1;
                    mem_wd = (i_reg == pos_reg) ? id_reg : rd_reg;
                    state_next = (i_reg == pos_reg) ? S_OUT : S_SHRD;
                end
                else
                begin
                    mem_we = (i_reg + 1'b1 < n_reg);
                    state_next = (i_reg + 1'b1 < n_reg) ? S_SHRD : S_OUT;
                    if (!(i_reg + 1'b1 < n_reg))
                    begin
                        mem_we = 1'b0;
                    end
                end
            end
            S_OUT:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic [CNT_W-1:0] fill_pick;
    assign fill_pick = fill_reg[sh_pick];

    // Datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int s = 0; s < SHARDS; s++)
            begin
                fill_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Drop the result once taken, unless a new one is loaded
            if (rsp_valid_reg && !rsp_stall && state_reg != S_OUT)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && !req_stall)
                    begin
                        op_reg  <= req.op;
                        id_reg  <= req.card_id;
                        sh_reg  <= sh_pick;
                        n_reg   <= fill_pick;
                        lo_reg  <= '0;
                        hi_reg  <= fill_pick;
                        mid_reg <= fill_pick >> 1;
                    end
                end
                S_CMP:
                begin
                    // Halve the search range
                    if (rd_reg < id_reg)
                    begin
                        lo_reg  <= mid_reg + 1'b1;
                        mid_reg <= mid_reg + 1'b1 + ((hi_reg - mid_reg - 1'b1) >> 1);
                    end
                    else
                    begin
                        hi_reg  <= mid_reg;
                        mid_reg <= lo_reg + ((mid_reg - lo_reg) >> 1);
                    end
                end
                S_PROBE:
                begin
                    if (!(lo_reg < hi_reg))
                    begin
                        mid_reg <= lo_reg;
                    end
                end
                S_DECIDE:
                begin
                    hit_reg <= hit;
                    pos_reg <= lo_reg;
                    i_reg   <= (op_reg == ssis_pkg::OP_ADD) ? n_reg : lo_reg;
                end
                S_SHWR:
                begin
                    if (op_reg == ssis_pkg::OP_ADD)
                    begin
                        i_reg <= i_reg - 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (!(rsp_valid_reg && rsp_stall))
                    begin
                        rsp_valid_reg       <= 1'b1;
                        rsp_reg.present     <= hit_reg;
                        rsp_reg.shard_index <= ssis_pkg::SHARD_IDX_W'(sh_reg);
                        case (op_reg)
                            ssis_pkg::OP_ADD:
                            begin
                                if (hit_reg)
                                begin
                                    rsp_reg.status <= ssis_pkg::ST_DUP;
                                end
                                else if (n_reg >= CNT_W'(ENTRIES_PER_SHARD))
                                begin
                                    rsp_reg.status <= ssis_pkg::ST_FULL;
                                end
                                else
                                begin
                                    rsp_reg.status <= ssis_pkg::ST_DONE;
                                    fill_reg[sh_reg] <= n_reg + 1'b1;
                                end
                            end
                            ssis_pkg::OP_DELETE:
                            begin
                                if (hit_reg)
                                begin
                                    rsp_reg.status <= ssis_pkg::ST_DONE;
                                    fill_reg[sh_reg] <= n_reg - 1'b1;
                                end
                                else
                                begin
                                    rsp_reg.status <= ssis_pkg::ST_MISSING;
                                end
                            end
                            default:
                            begin
                                rsp_reg.status <= hit_reg ? ssis_pkg::ST_DONE
                                                          : ssis_pkg::ST_MISSING;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/sharded_sorted_id_set_test.sv
// Testbench for the sharded sorted ID set: directed table, a shard fill, then random items.
// Depends on ssis_pkg and the sharded_sorted_id_set top level.
`timescale 1ns / 1ps
module sharded_sorted_id_set_test;

    localparam int NSH = 32;
    localparam int NENT = 64;
    localparam int WATCH_LIMIT = 20000;
    localparam int RAND_ITEMS = 740;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    ssis_pkg::req_t req = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    ssis_pkg::rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall = 1'b0;

    sharded_sorted_id_set DUT (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the shard tables
    logic [63:0] shadow_tab [NSH][NENT];
    int unsigned shadow_fill [NSH];
    ssis_pkg::rsp_t pending_rsp [$];
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit timed_out = 1'b0;
    logic [63:0] pool [16];

    function automatic logic [4:0] fold_shard(logic [63:0] id);
        logic [31:0] f;
        f = id[63:32] ^ id[31:0];
        return f[4:0];
    endfunction

    // Predict the response and update the shadow tables
    function automatic ssis_pkg::rsp_t apply_op(ssis_pkg::req_t r);
        ssis_pkg::rsp_t o;
        logic [4:0] s;
        int unsigned n, lo, hi, mid;
        bit hit;
        ssis_pkg::status_t st;
        s = fold_shard(r.card_id);
        n = shadow_fill[s];
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (shadow_tab[s][mid] < r.card_id) lo = mid + 1;
            else hi = mid;
        end
        hit = (lo < n) && (shadow_tab[s][lo] == r.card_id);
        if (r.op == ssis_pkg::OP_ADD)
        begin
            if (hit) st = ssis_pkg::ST_DUP;
            else if (n >= NENT) st = ssis_pkg::ST_FULL;
            else
            begin
                for (int i = n; i > lo; i--) shadow_tab[s][i] = shadow_tab[s][i-1];
                shadow_tab[s][lo] = r.card_id;
                shadow_fill[s] = n + 1;
                st = ssis_pkg::ST_DONE;
            end
        end
        else if (r.op == ssis_pkg::OP_DELETE)
        begin
            if (hit)
            begin
                for (int i = lo; i + 1 < n; i++) shadow_tab[s][i] = shadow_tab[s][i+1];
                shadow_fill[s] = n - 1;
                st = ssis_pkg::ST_DONE;
            end
            else st = ssis_pkg::ST_MISSING;
        end
        else st = hit ? ssis_pkg::ST_DONE : ssis_pkg::ST_MISSING;
        o.present = hit;
        o.status = st;
        o.shard_index = s;
        return o;
    endfunction

    // Send one item; check the typed expectation when given
    task automatic send_item(ssis_pkg::req_t r, bit has_exp, ssis_pkg::rsp_t exp_rsp);
        ssis_pkg::rsp_t p;
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        p = apply_op(r);
        if (has_exp && p !== exp_rsp)
        begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: typed %h predicted %h", exp_rsp, p);
        end
        pending_rsp.push_back(p);
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Check each accepted response against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected response %h", rsp);
            end
            else
            begin
                if (rsp !== pending_rsp[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h actual %h", pending_rsp[0], rsp);
                end
                void'(pending_rsp.pop_front());
            end
        end
    end

    // Stall the response side in random bursts
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 16);
                rsp_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            rsp_stall <= 1'b0;
        end
    end

    // Count cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAIL sharded_sorted_id_set");
            $finish;
        end
    end

    function automatic ssis_pkg::req_t mk(ssis_pkg::op_t o, logic [63:0] id);
        ssis_pkg::req_t r;
        r.op = o;
        r.card_id = id;
        return r;
    endfunction

    function automatic ssis_pkg::rsp_t mr(logic p, ssis_pkg::status_t st, logic [4:0] s);
        ssis_pkg::rsp_t o;
        o.present = p;
        o.status = st;
        o.shard_index = s;
        return o;
    endfunction

    typedef struct {
        ssis_pkg::req_t r;
        bit has_exp;
        ssis_pkg::rsp_t e;
    } row_t;

    initial
    begin
        row_t rows [$];
        ssis_pkg::req_t r;
        logic [63:0] id;
        int k;
        for (int s = 0; s < NSH; s++) shadow_fill[s] = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: extremes, every op, dup, missing, spare op
        rows.push_back('{mk(ssis_pkg::OP_LOOKUP, 64'h0), 1,
                         mr(0, ssis_pkg::ST_MISSING, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_DELETE, 64'h0), 1,
                         mr(0, ssis_pkg::ST_MISSING, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_ADD, 64'h0), 1,
                         mr(0, ssis_pkg::ST_DONE, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_ADD, 64'h0), 1,
                         mr(1, ssis_pkg::ST_DUP, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_LOOKUP, 64'h0), 1,
                         mr(1, ssis_pkg::ST_DONE, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_SPARE, 64'h0), 1,
                         mr(1, ssis_pkg::ST_DONE, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_ADD, '1), 1,
                         mr(0, ssis_pkg::ST_DONE, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_ADD, 64'h0000_0000_FFFF_FFFF), 1,
                         mr(0, ssis_pkg::ST_DONE, 5'd31)});
        rows.push_back('{mk(ssis_pkg::OP_ADD, 64'hFFFF_FFFF_0000_0000), 0, '0});
        rows.push_back('{mk(ssis_pkg::OP_DELETE, 64'h0), 1,
                         mr(1, ssis_pkg::ST_DONE, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_LOOKUP, 64'h0), 1,
                         mr(0, ssis_pkg::ST_MISSING, 5'd0)});
        rows.push_back('{mk(ssis_pkg::OP_SPARE, 64'h1234), 0, '0});
        rows.push_back('{mk(ssis_pkg::OP_LOOKUP, '1), 0, '0});
        foreach (rows[i]) send_item(rows[i].r, rows[i].has_exp, rows[i].e);

        // Fill shard 7 past capacity with descending IDs, then drain half
        for (int i = 0; i < NENT + 3; i++)
        begin
            id = {32'h0, 32'((NENT + 3 - i) * 32 + 7)};
            send_item(mk(ssis_pkg::OP_ADD, id), 0, '0);
        end
        for (int i = 0; i < NENT; i += 2)
            send_item(mk(ssis_pkg::OP_DELETE, {32'h0, 32'((i + 1) * 32 + 7)}), 0, '0);

        // Random items over a small pool so hits and deletes are common
        for (int i = 0; i < 16; i++) pool[i] = {$urandom, $urandom};
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i > RAND_ITEMS - 120) calm = 1'b1;
            k = $urandom_range(0, 9);
            if (k < 6) id = pool[$urandom_range(0, 15)];
            else if (k < 8) id = {$urandom, $urandom};
            else id = {$urandom, 27'h0, 5'($urandom_range(0, 1))};
            r.op = ssis_pkg::op_t'($urandom_range(0, 9) < 4 ? ssis_pkg::OP_ADD :
                         ($urandom_range(0, 3) == 0 ? 2'($urandom_range(0, 3))
                                                    : ssis_pkg::OP_DELETE));
            r.card_id = id;
            if ($urandom_range(0, 3) == 0) r.op = ssis_pkg::OP_LOOKUP;
            send_item(r, 0, '0);
        end
        req_valid <= 1'b0;

        calm = 1'b1;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("PASS sharded_sorted_id_set");
        else
            $display("FAIL sharded_sorted_id_set");
        $finish;
    end
endmodule
